// ===== design/qnn_pkg.sv =====
// qnn_pkg: word types and shared constants for the quad newell normal block
// no dependencies; used by every module of the block
`default_nettype none

package qnn_pkg;

    localparam int CoordW  = 16;
    localparam int RawW    = 36;
    localparam int MagW    = 31;
    localparam int SumW    = 64;
    localparam int RootW   = 32;
    localparam int QuotW   = 15;
    localparam int SqrtNs  = 32;
    localparam int DivNs   = 16;

    typedef struct packed {
        logic signed [CoordW-1:0] corner0_x;
        logic signed [CoordW-1:0] corner0_y;
        logic signed [CoordW-1:0] corner0_z;
        logic signed [CoordW-1:0] corner1_x;
        logic signed [CoordW-1:0] corner1_y;
        logic signed [CoordW-1:0] corner1_z;
        logic signed [CoordW-1:0] corner2_x;
        logic signed [CoordW-1:0] corner2_y;
        logic signed [CoordW-1:0] corner2_z;
        logic signed [CoordW-1:0] corner3_x;
        logic signed [CoordW-1:0] corner3_y;
        logic signed [CoordW-1:0] corner3_z;
    } face_word_t;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic               degenerate;
    } norm_word_t;

    typedef struct packed {
        logic [2:0]            neg;
        logic                  degen;
        logic [2:0][MagW-1:0]  mag;
    } side_t;

endpackage

`default_nettype wire

// ===== design/quad_newell_normal.sv =====
// quad_newell_normal: top level, lanes, normalize and merge, output register
// depends on qnn_pkg, qnn_lane, qnn_sqrt, qnn_div
//
// use: face words (four corners, signed q8.8) enter on face_valid/face_ready;
// unit normal words (signed q1.14 plus degenerate flag) leave on
// norm_valid/norm_ready
// throughput: one face word per cycle while the output is not stalled, set by the fully pipelined datapath
// pipeline, from accept to norm_valid:
//   newell lanes, magnitude, normalize and square sum,
//   square root (one bit per stage), divide lanes,
//   1 output register
// stall: a full stage holds while its successor is full and holding, so
//   empty stages keep filling while a word waits at the output; face_ready
//   drops only when every stage is full
// reset: clears all stage valid bits; datapath registers are not reset
`default_nettype none

module quad_newell_normal
    import qnn_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        face_valid,
    output logic             face_ready,
    input  wire face_word_t  face,
    output logic             norm_valid,
    input  wire logic        norm_ready,
    output norm_word_t       norm
);

    localparam int SqBase  = 7;
    localparam int DivBase = SqBase + SqrtNs;
    localparam int OutSt   = DivBase + DivNs;
    localparam int NumSt   = OutSt + 1;

    logic [NumSt:0]   en;
    logic [NumSt-1:0] vld_reg;

    assign en[NumSt] = norm_ready;
    for (genvar i = 0; i < NumSt; i++)
    begin : g_en
        assign en[i] = !vld_reg[i] || en[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= face_valid;
            end
            for (int i = 1; i < NumSt; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    assign face_ready = en[0];
    assign norm_valid = vld_reg[NumSt-1];

    // newell lanes
    logic signed [CoordW-1:0] cx [4];
    logic signed [CoordW-1:0] cy [4];
    logic signed [CoordW-1:0] cz [4];
    logic signed [RawW-1:0]   n_raw [3];

    assign cx = '{face.corner0_x, face.corner1_x, face.corner2_x, face.corner3_x};
    assign cy = '{face.corner0_y, face.corner1_y, face.corner2_y, face.corner3_y};
    assign cz = '{face.corner0_z, face.corner1_z, face.corner2_z, face.corner3_z};

    qnn_lane u_lane_x (.clk(clk), .en(en[1:0]), .u(cy), .w(cz), .n(n_raw[0]));
    qnn_lane u_lane_y (.clk(clk), .en(en[1:0]), .u(cz), .w(cx), .n(n_raw[1]));
    qnn_lane u_lane_z (.clk(clk), .en(en[1:0]), .u(cx), .w(cy), .n(n_raw[2]));

    // magnitudes
    logic [RawW-1:0] mag2_reg [3];
    logic [2:0]      neg2_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int c = 0; c < 3; c++)
            begin
                mag2_reg[c] <= n_raw[c][RawW-1] ? RawW'(-n_raw[c]) : RawW'(n_raw[c]);
                neg2_reg[c] <= !n_raw[c][RawW-1] && (n_raw[c] != '0);
            end
        end
    end

    // largest magnitude and its leading one
    logic [RawW-1:0] mmax;
    logic [5:0]      lead;
    logic [RawW-1:0] mag3_reg [3];
    logic [2:0]      neg3_reg;
    logic            degen3_reg;
    logic [2:0]      rs3_reg;
    logic [4:0]      ls3_reg;

    always_comb
    begin
        mmax = mag2_reg[0];
        if (mag2_reg[1] > mmax)
        begin
            mmax = mag2_reg[1];
        end
        if (mag2_reg[2] > mmax)
        begin
            mmax = mag2_reg[2];
        end
        lead = '0;
        for (int i = 0; i < RawW; i++)
        begin
            if (mmax[i])
            begin
                lead = 6'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            mag3_reg   <= mag2_reg;
            neg3_reg   <= neg2_reg;
            degen3_reg <= (mmax == '0);
            rs3_reg    <= (lead > 6'd30) ? 3'(lead - 6'd30) : 3'd0;
            ls3_reg    <= (lead < 6'd30) ? 5'(6'd30 - lead) : 5'd0;
        end
    end

    // normalized magnitudes, squares and their sum
    side_t          side_reg [4:OutSt-1];
    logic [61:0]    sq_reg [3];
    logic [SumW-1:0] s_reg;
    logic [RawW-1:0] shifted [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            shifted[c] = (mag3_reg[c] >> rs3_reg) << ls3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            side_reg[4].neg   <= neg3_reg;
            side_reg[4].degen <= degen3_reg;
            for (int c = 0; c < 3; c++)
            begin
                side_reg[4].mag[c] <= shifted[c][MagW-1:0];
            end
        end
        if (en[5])
        begin
            for (int c = 0; c < 3; c++)
            begin
                sq_reg[c] <= 62'(side_reg[4].mag[c]) * 62'(side_reg[4].mag[c]);
            end
        end
        if (en[6])
        begin
            s_reg <= SumW'(sq_reg[0]) + SumW'(sq_reg[1]) + SumW'(sq_reg[2]);
        end
    end

    for (genvar i = 5; i < OutSt; i++)
    begin : g_side
        always_ff @(posedge clk)
        begin
            if (en[i])
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // square root, then three divide lanes
    logic [RootW-1:0] len;
    logic [QuotW-1:0] q [3];

    qnn_sqrt u_sqrt (
        .clk  (clk),
        .en   (en[DivBase-1:SqBase]),
        .s    (s_reg),
        .root (len)
    );

    for (genvar c = 0; c < 3; c++)
    begin : g_div
        qnn_div u_div (
            .clk (clk),
            .en  (en[OutSt-1:DivBase]),
            .mag (side_reg[DivBase-1].mag[c]),
            .len (len),
            .q   (q[c])
        );
    end

    // sign and output register
    norm_word_t norm_reg;
    logic [15:0] comp [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (side_reg[OutSt-1].degen)
            begin
                comp[c] = '0;
            end
            else if (side_reg[OutSt-1].neg[c])
            begin
                comp[c] = 16'(-{1'b0, q[c]});
            end
            else
            begin
                comp[c] = {1'b0, q[c]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[OutSt])
        begin
            norm_reg.normal_x   <= comp[0];
            norm_reg.normal_y   <= comp[1];
            norm_reg.normal_z   <= comp[2];
            norm_reg.degenerate <= side_reg[OutSt-1].degen;
        end
    end

    assign norm = norm_reg;

endmodule

`default_nettype wire

// ===== design/qnn_lane.sv =====
// qnn_lane: one newell component, a product for each of the quad's edges, then their sum
// depends on qnn_pkg
`default_nettype none

module qnn_lane
    import qnn_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic [1:0]               en,
    input  wire logic signed [CoordW-1:0] u [4],
    input  wire logic signed [CoordW-1:0] w [4],
    output logic signed [RawW-1:0]        n
);

    logic signed [2*CoordW+1:0] prod_reg [4];
    logic signed [RawW-1:0]     n_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int k = 0; k < 4; k++)
            begin
                prod_reg[k] <= (34'(signed'(u[(k+1)%4])) - 34'(signed'(u[k])))
                             * (34'(signed'(w[(k+1)%4])) + 34'(signed'(w[k])));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            n_reg <= RawW'(prod_reg[0]) + RawW'(prod_reg[1])
                   + RawW'(prod_reg[2]) + RawW'(prod_reg[3]);
        end
    end

    assign n = n_reg;

endmodule

`default_nettype wire

// ===== design/qnn_sqrt.sv =====
// qnn_sqrt: pipelined integer square root, one root bit per stage
// depends on qnn_pkg
`default_nettype none

module qnn_sqrt
    import qnn_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [SqrtNs-1:0] en,
    input  wire logic [SumW-1:0]   s,
    output logic [RootW-1:0]       root
);

    logic [34:0]      rem_reg  [SqrtNs];
    logic [RootW-1:0] root_reg [SqrtNs];
    logic [SumW-1:0]  src_reg  [SqrtNs];

    for (genvar k = 0; k < SqrtNs; k++)
    begin : g_stage
        logic [34:0]      rem_in;
        logic [RootW-1:0] root_in;
        logic [SumW-1:0]  src_in;
        logic [34:0]      cur;
        logic [34:0]      trial;

        if (k == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign src_in  = s;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign src_in  = src_reg[k-1];
        end

        assign cur   = {rem_in[32:0], src_in[SumW-1:SumW-2]};
        assign trial = {1'b0, root_in, 2'b01};

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                src_reg[k] <= {src_in[SumW-3:0], 2'b00};
                if (cur >= trial)
                begin
                    rem_reg[k]  <= cur - trial;
                    root_reg[k] <= {root_in[RootW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k]  <= cur;
                    root_reg[k] <= {root_in[RootW-2:0], 1'b0};
                end
            end
        end
    end

    assign root = root_reg[SqrtNs-1];

endmodule

`default_nettype wire

// ===== design/qnn_div.sv =====
// qnn_div: pipelined rounded divide mag * 2^14 / len, a setup stage then one quotient bit per stage
// depends on qnn_pkg
`default_nettype none

module qnn_div
    import qnn_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [DivNs-1:0]  en,
    input  wire logic [MagW-1:0]   mag,
    input  wire logic [RootW-1:0]  len,
    output logic [QuotW-1:0]       q
);

    logic [47:0]      rem_reg [DivNs];
    logic [32:0]      d_reg   [DivNs];
    logic [QuotW-1:0] q_reg   [DivNs];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0] <= {2'b00, mag, 15'd0} + 48'(len);
            d_reg[0]   <= {len, 1'b0};
            q_reg[0]   <= '0;
        end
    end

    for (genvar t = 1; t < DivNs; t++)
    begin : g_stage
        logic [47:0] dsh;
        assign dsh = 48'(d_reg[t-1]) << (QuotW - t);

        always_ff @(posedge clk)
        begin
            if (en[t])
            begin
                d_reg[t] <= d_reg[t-1];
                if (rem_reg[t-1] >= dsh)
                begin
                    rem_reg[t] <= rem_reg[t-1] - dsh;
                    q_reg[t]   <= q_reg[t-1] | (QuotW'(1) << (QuotW - t));
                end
                else
                begin
                    rem_reg[t] <= rem_reg[t-1];
                    q_reg[t]   <= q_reg[t-1];
                end
            end
        end
    end

    assign q = q_reg[DivNs-1];

endmodule

`default_nettype wire

// ===== verif/qnn_checker.sv =====
// qnn_checker: watches the face and normal channels of quad_newell_normal,
// predicts each unit normal word and compares it; depends on qnn_pkg
`timescale 1ns / 100ps

module qnn_checker
    import qnn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       face_valid,
    input  logic       face_ready,
    input  face_word_t face,
    input  logic       norm_valid,
    input  logic       norm_ready,
    input  norm_word_t norm,
    output int         errors,
    output int         pending,
    output int         faces_seen,
    output int         degen_seen
);

    norm_word_t expected_normals[$];

    function automatic logic [63:0] int_root(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic norm_word_t newell_unit_normal(input face_word_t f);
        logic signed [63:0] pt[4][3];
        logic signed [63:0] raw[3];
        logic [63:0] mag[3];
        logic [63:0] top;
        logic [63:0] sq;
        logic [63:0] len;
        logic [63:0] q;
        logic signed [63:0] acc;
        logic signed [15:0] comp[3];
        norm_word_t res;
        int u;
        int w;
        int nk;
        pt[0][0] = f.corner0_x; pt[0][1] = f.corner0_y; pt[0][2] = f.corner0_z;
        pt[1][0] = f.corner1_x; pt[1][1] = f.corner1_y; pt[1][2] = f.corner1_z;
        pt[2][0] = f.corner2_x; pt[2][1] = f.corner2_y; pt[2][2] = f.corner2_z;
        pt[3][0] = f.corner3_x; pt[3][1] = f.corner3_y; pt[3][2] = f.corner3_z;
        top = 0;
        for (int c = 0; c < 3; c++)
        begin
            u = (c + 1) % 3;
            w = (c + 2) % 3;
            acc = 0;
            for (int k = 0; k < 4; k++)
            begin
                nk = (k + 1) % 4;
                acc = acc + (pt[nk][u] - pt[k][u]) * (pt[nk][w] + pt[k][w]);
            end
            raw[c] = acc;
            mag[c] = (acc < 0) ? -acc : acc;
            if (mag[c] > top)
                top = mag[c];
        end
        res = '0;
        if (top == 0)
        begin
            res.degenerate = 1'b1;
            return res;
        end
        while (top >= (64'd1 << 31))
        begin
            top = top >> 1;
            for (int c = 0; c < 3; c++)
                mag[c] = mag[c] >> 1;
        end
        while (top < (64'd1 << 30))
        begin
            top = top << 1;
            for (int c = 0; c < 3; c++)
                mag[c] = mag[c] << 1;
        end
        sq = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        len = int_root(sq);
        for (int c = 0; c < 3; c++)
        begin
            q = ((mag[c] << 15) + len) / (len << 1);
            comp[c] = (raw[c] > 0) ? -q[15:0] : q[15:0];
        end
        res.normal_x = comp[0];
        res.normal_y = comp[1];
        res.normal_z = comp[2];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    initial
    begin
        errors = 0;
        pending = 0;
        faces_seen = 0;
        degen_seen = 0;
    end

    always @(posedge clk)
    begin
        norm_word_t want;
        if (rst_n && face_valid && face_ready)
        begin
            expected_normals.insert(expected_normals.size(), newell_unit_normal(face));
            faces_seen++;
        end
        if (rst_n && norm_valid && norm_ready)
        begin
            if (expected_normals.size() == 0)
                report_mismatch("unexpected word", 1, 0);
            else
            begin
                want = expected_normals.pop_front();
                if (want.degenerate)
                    degen_seen++;
                if (norm.normal_x !== want.normal_x)
                    report_mismatch("normal_x", norm.normal_x, want.normal_x);
                if (norm.normal_y !== want.normal_y)
                    report_mismatch("normal_y", norm.normal_y, want.normal_y);
                if (norm.normal_z !== want.normal_z)
                    report_mismatch("normal_z", norm.normal_z, want.normal_z);
                if (norm.degenerate !== want.degenerate)
                    report_mismatch("degenerate", norm.degenerate, want.degenerate);
            end
        end
        pending = expected_normals.size();
    end

endmodule

// ===== verif/tb.sv =====
// tb: stimulus and verdict for quad_newell_normal
// depends on qnn_pkg, the block, and qnn_checker for prediction and compare
`timescale 1ns / 100ps

module tb;
    import qnn_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       face_valid;
    logic       face_ready;
    face_word_t face;
    logic       norm_valid;
    logic       norm_ready;
    norm_word_t norm;
    int         errors;
    int         pending;
    int         faces_seen;
    int         degen_seen;
    int         cycles;
    bit         calm;
    int         hold_off;

    quad_newell_normal dut (
        .clk(clk), .rst_n(rst_n),
        .face_valid(face_valid), .face_ready(face_ready), .face(face),
        .norm_valid(norm_valid), .norm_ready(norm_ready), .norm(norm)
    );

    qnn_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .face_valid(face_valid), .face_ready(face_ready), .face(face),
        .norm_valid(norm_valid), .norm_ready(norm_ready), .norm(norm),
        .errors(errors), .pending(pending),
        .faces_seen(faces_seen), .degen_seen(degen_seen)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 400000)
            begin
                $display("timeout after %0d cycles", cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    // receiver: random stalls, long hold-off on request
    initial
    begin
        norm_ready = 0;
        hold_off = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                hold_off--;
                norm_ready <= 0;
            end
            else
                norm_ready <= calm || ($urandom_range(99) >= 32);
        end
    end

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($urandom_range(15) - 8);
            4: return 16'($urandom_range(2047) - 1024);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic face_word_t random_face();
        face_word_t f;
        int kind;
        kind = $urandom_range(9);
        f.corner0_x = pick_coord(); f.corner0_y = pick_coord(); f.corner0_z = pick_coord();
        f.corner1_x = pick_coord(); f.corner1_y = pick_coord(); f.corner1_z = pick_coord();
        f.corner2_x = pick_coord(); f.corner2_y = pick_coord(); f.corner2_z = pick_coord();
        f.corner3_x = pick_coord(); f.corner3_y = pick_coord(); f.corner3_z = pick_coord();
        if (kind == 0)
        begin
            // all corners coincide: degenerate
            f.corner1_x = f.corner0_x; f.corner1_y = f.corner0_y; f.corner1_z = f.corner0_z;
            f.corner2_x = f.corner0_x; f.corner2_y = f.corner0_y; f.corner2_z = f.corner0_z;
            f.corner3_x = f.corner0_x; f.corner3_y = f.corner0_y; f.corner3_z = f.corner0_z;
        end
        else if (kind == 1)
        begin
            // planar quad at constant z
            f.corner1_z = f.corner0_z; f.corner2_z = f.corner0_z; f.corner3_z = f.corner0_z;
        end
        return f;
    endfunction

    task automatic send_face(input face_word_t f);
        while (!calm && $urandom_range(99) < 32)
        begin
            face_valid <= 0;
            @(negedge clk);
        end
        face_valid <= 1;
        face <= f;
        @(posedge clk);
        while (!face_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_corner_set(input logic [15:0] v0, input logic [15:0] v1,
                                   input logic [15:0] v2, input logic [15:0] v3);
        face_word_t f;
        f = '{v0, v1, v2, v0, v2, v3, v3, v1, v0, v2, v3, v1};
        send_face(f);
    endtask

    initial
    begin
        face_word_t f;
        calm = 0;
        rst_n = 0;
        face_valid = 0;
        face = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: extremes, zero, unit square, degenerate, line
        send_face('0);
        send_face({12{16'h7fff}});
        send_face({12{16'h8000}});
        f = '0;
        f.corner1_x = 16'h0100;
        f.corner2_x = 16'h0100; f.corner2_y = 16'h0100;
        f.corner3_y = 16'h0100;
        send_face(f);
        f.corner1_x = 16'h0001; f.corner2_x = 16'h0001; f.corner2_y = 16'h0001;
        f.corner3_y = 16'h0001;
        send_face(f);
        send_corner_set(16'h8000, 16'h7fff, 16'h0000, 16'hffff);
        send_corner_set(16'h7fff, 16'h8000, 16'hffff, 16'h0001);
        send_corner_set(16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
        send_corner_set(16'h5555, 16'haaaa, 16'h0f0f, 16'hf0f0);
        send_corner_set(16'haaaa, 16'h5555, 16'hf0f0, 16'h0f0f);
        f = '0;
        f.corner1_x = 16'h0100; f.corner2_x = 16'h0200; f.corner3_x = 16'h0300;
        send_face(f);
        for (int i = 0; i < 10; i++)
            send_face(random_face());

        // sender pause until drained
        face_valid <= 0;
        while (pending != 0)
            @(negedge clk);

        // long receiver hold-off while offering faces
        hold_off = 150;
        for (int i = 0; i < 120; i++)
            send_face(random_face());

        for (int i = 0; i < 1400; i++)
        begin
            calm = (i >= 600 && i < 800);
            send_face(random_face());
        end
        calm = 0;

        face_valid <= 0;
        while (pending != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);

        $display("covered %0d faces, %0d degenerate, extremes and planar quads",
                 faces_seen, degen_seen);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
